FILE: rtl/assert_macros.svh
// Assertion macros shared by the demand paging engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DPR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dpr_pkg.sv
// Package for the demand paging engine: field widths, reset values, codes,
// state and command types. No dependencies.
`default_nettype none

package dpr_pkg;

  localparam int NUM_PAGES_DEF  = 64;
  localparam int NUM_FRAMES_DEF = 32;

  localparam int PAGE_W     = 6;
  localparam int FRAME_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 32;
  localparam int MAXF_W     = 6;
  localparam int PIU_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [MAXF_W-1:0] RESET_MAX_FRAMES   = 6'd6;
  localparam logic [PIU_W-1:0]  RESET_PAGES_IN_USE = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FRAMES   = 2'd0,
    CFG_POLICY       = 2'd1,
    CFG_PAGES_IN_USE = 2'd2
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RESIDENT = 2'd1,
    ST_MISS     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_RANGE,
    RES_MISS,
    RES_ACCESS,
    RES_RESIDENT,
    RES_ALLOC,
    RES_EVICT
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_QRD,
    S_QWAIT,
    S_CHECK,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      paddr_head;
    logic      do_access;
    logic      do_alloc;
    logic      guard_clr;
    logic      do_rotate;
    logic      do_evict;
    logic      res_load;
    res_kind_t res_kind;
    logic      push_out;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_fault;
    logic hit;
    logic can_alloc;
    logic skip;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/dpr_if.sv
// Channel interfaces of the demand paging engine: request, response, config.
// Depends on dpr_pkg for field widths.
`default_nettype none

interface dpr_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [dpr_pkg::PAGE_W-1:0]     page;
  logic                           is_write;
  modport source (output valid, opcode, page, is_write, input ready);
  modport sink (input valid, opcode, page, is_write, output ready);
endinterface

interface dpr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dpr_pkg::STATUS_W-1:0]   status;
  logic [dpr_pkg::FRAME_W-1:0]    frame;
  logic                           replaced;
  logic [dpr_pkg::PAGE_W-1:0]     victim_page;
  logic                           writeback;
  logic [dpr_pkg::COUNT_W-1:0]    fault_count;
  logic [dpr_pkg::COUNT_W-1:0]    writeback_count;
  modport source (output valid, status, frame, replaced, victim_page, writeback,
                  fault_count, writeback_count, input ready);
  modport sink (input valid, status, frame, replaced, victim_page, writeback,
                fault_count, writeback_count, output ready);
endinterface

interface dpr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpr_pkg::CFG_IDX_W-1:0]   index;
  logic [dpr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/dpr_ctrl.sv
// Sequencer of the demand paging engine: steps lookup, replacement scan and
// result hand-off. Depends on dpr_pkg for state, command and status types.
`default_nettype none

module dpr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire dpr_pkg::stat_t st,
  output logic                in_ready,
  output dpr_pkg::cmd_t       cmd
);

  dpr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dpr_pkg::S_IDLE: begin
        if (in_valid) state_next = dpr_pkg::S_LOOKUP;
      end
      dpr_pkg::S_LOOKUP: begin
        if (st.in_range && st.is_fault && !st.hit && !st.can_alloc) begin
          state_next = dpr_pkg::S_QRD;
        end else begin
          state_next = dpr_pkg::S_PUSH;
        end
      end
      dpr_pkg::S_QRD:   state_next = dpr_pkg::S_QWAIT;
      dpr_pkg::S_QWAIT: state_next = dpr_pkg::S_CHECK;
      dpr_pkg::S_CHECK: begin
        state_next = st.skip ? dpr_pkg::S_QRD : dpr_pkg::S_PUSH;
      end
      dpr_pkg::S_PUSH: begin
        if (st.out_free) state_next = dpr_pkg::S_IDLE;
      end
      default: state_next = dpr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dpr_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      dpr_pkg::S_LOOKUP: begin
        if (!st.in_range) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = dpr_pkg::RES_RANGE;
        end else if (!st.is_fault) begin
          cmd.res_load  = 1'b1;
          cmd.do_access = st.hit;
          cmd.res_kind  = st.hit ? dpr_pkg::RES_ACCESS : dpr_pkg::RES_MISS;
        end else if (st.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = dpr_pkg::RES_RESIDENT;
        end else if (st.can_alloc) begin
          cmd.res_load = 1'b1;
          cmd.do_alloc = 1'b1;
          cmd.res_kind = dpr_pkg::RES_ALLOC;
        end else begin
          cmd.guard_clr = 1'b1;
        end
      end
      dpr_pkg::S_QWAIT: begin
        cmd.paddr_head = 1'b1;
      end
      dpr_pkg::S_CHECK: begin
        if (st.skip) begin
          cmd.do_rotate = 1'b1;
        end else begin
          cmd.do_evict = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = dpr_pkg::RES_EVICT;
        end
      end
      dpr_pkg::S_PUSH: begin
        cmd.push_out = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/dpr_dpath.sv
// Datapath of the demand paging engine: config registers, page table RAM,
// arrival queue RAM, counters and output register. Depends on dpr_pkg,
// dpr_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dpr_dpath #(
  parameter int NUM_PAGES  = dpr_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = dpr_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [dpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             req_opcode,
  input  wire logic [dpr_pkg::PAGE_W-1:0]       req_page,
  input  wire logic                             req_is_write,
  input  wire dpr_pkg::cmd_t                    cmd,
  output dpr_pkg::stat_t                        st,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [dpr_pkg::STATUS_W-1:0]          out_status,
  output logic [dpr_pkg::FRAME_W-1:0]           out_frame,
  output logic                                  out_replaced,
  output logic [dpr_pkg::PAGE_W-1:0]            out_victim_page,
  output logic                                  out_writeback,
  output logic [dpr_pkg::COUNT_W-1:0]           out_fault_count,
  output logic [dpr_pkg::COUNT_W-1:0]           out_writeback_count
);

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int FUW = $clog2(NUM_FRAMES + 1);
  localparam int SW  = FUW + 1;
  localparam int LW  = (FUW > dpr_pkg::MAXF_W) ? FUW : dpr_pkg::MAXF_W;
  localparam int PRW = FW + 2;

  // config
  logic [dpr_pkg::MAXF_W-1:0] max_frames;
  logic                       policy;
  logic [dpr_pkg::PIU_W-1:0]  pages_in_use;

  // latched item
  logic                       op_q;
  logic [dpr_pkg::PAGE_W-1:0] page_q;
  logic                       wr_q;

  // engine state; queue count always equals frames_used, and frames are
  // handed out in ascending order, so frames_used is also the lowest free frame
  logic [NUM_PAGES-1:0]       page_valid;
  logic [FUW-1:0]             frames_used;
  logic [FW-1:0]              queue_head;
  logic [FUW-1:0]             guard;
  logic [dpr_pkg::COUNT_W-1:0] faults_total;
  logic [dpr_pkg::COUNT_W-1:0] writebacks_total;

  // pending result
  dpr_pkg::status_t           res_status;
  logic [FW-1:0]              res_frame;
  logic                       res_replaced;
  logic [PW-1:0]              res_victim;
  logic                       res_wb;

  // RAM ports; page word is {frame, dirty, chance}
  logic           pr_we;
  logic [PW-1:0]  pr_waddr;
  logic [PRW-1:0] pr_wdata;
  logic [PW-1:0]  pr_raddr;
  logic [PRW-1:0] pr_rdata;
  logic           q_we;
  logic [FW-1:0]  q_waddr;
  logic [PW-1:0]  q_wdata;
  logic [PW-1:0]  q_rdata;

  logic [PW-1:0]  page_idx;
  logic [FW-1:0]  pr_frame;
  logic           pr_dirty;
  logic           pr_chance;
  logic [LW-1:0]  limit;
  logic [SW-1:0]  tail_sum;
  logic [FW-1:0]  queue_tail;
  logic [FW-1:0]  head_inc;

  assign page_idx  = PW'(page_q);
  assign pr_frame  = pr_rdata[PRW-1:2];
  assign pr_dirty  = pr_rdata[1];
  assign pr_chance = pr_rdata[0];

  always_comb begin
    if (max_frames == '0) begin
      limit = LW'(1);
    end else if (LW'(max_frames) > LW'(NUM_FRAMES)) begin
      limit = LW'(NUM_FRAMES);
    end else begin
      limit = LW'(max_frames);
    end
  end

  always_comb begin
    tail_sum = SW'(queue_head) + SW'(frames_used);
    if (tail_sum >= SW'(NUM_FRAMES)) begin
      tail_sum = tail_sum - SW'(NUM_FRAMES);
    end
    queue_tail = FW'(tail_sum);
    head_inc   = (queue_head == FW'(NUM_FRAMES - 1)) ? '0 : queue_head + 1'b1;
  end

  assign st.in_range  = (dpr_pkg::PIU_W'(page_q) < pages_in_use) &&
                        (32'(page_q) < NUM_PAGES);
  assign st.is_fault  = op_q;
  assign st.hit       = page_valid[page_idx];
  assign st.can_alloc = LW'(frames_used) < limit;
  assign st.skip      = policy && (guard < frames_used) && pr_chance;
  assign st.out_free  = !out_valid || out_ready;

  // page table read address and writes
  assign pr_raddr = cmd.paddr_head ? q_rdata : PW'(req_page);

  always_comb begin
    pr_we    = 1'b0;
    pr_waddr = page_idx;
    pr_wdata = pr_rdata;
    if (cmd.do_access) begin
      pr_we    = 1'b1;
      pr_wdata = {pr_frame, pr_dirty | wr_q, 1'b1};
    end else if (cmd.do_alloc) begin
      pr_we    = 1'b1;
      pr_wdata = {FW'(frames_used), 2'b00};
    end else if (cmd.do_rotate) begin
      pr_we    = 1'b1;
      pr_waddr = q_rdata;
      pr_wdata = {pr_frame, pr_dirty, 1'b0};
    end else if (cmd.do_evict) begin
      // replacement load starts with its chance mark set
      pr_we    = 1'b1;
      pr_wdata = {pr_frame, 2'b01};
    end
  end

  assign q_we    = cmd.do_alloc || cmd.do_rotate || cmd.do_evict;
  assign q_waddr = queue_tail;
  assign q_wdata = cmd.do_rotate ? q_rdata : page_idx;

  dpr_ram #(.WIDTH(PRW), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  dpr_ram #(.WIDTH(PW), .DEPTH(NUM_FRAMES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (queue_head),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames   <= dpr_pkg::RESET_MAX_FRAMES;
      policy       <= 1'b0;
      pages_in_use <= dpr_pkg::RESET_PAGES_IN_USE;
    end else if (cfg_we) begin
      case (cfg_index)
        dpr_pkg::CFG_MAX_FRAMES:   max_frames   <= cfg_data[dpr_pkg::MAXF_W-1:0];
        dpr_pkg::CFG_POLICY:       policy       <= cfg_data[0];
        dpr_pkg::CFG_PAGES_IN_USE: pages_in_use <= cfg_data[dpr_pkg::PIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= req_opcode;
      page_q <= req_page;
      wr_q   <= req_is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid       <= '0;
      frames_used      <= '0;
      queue_head       <= '0;
      guard            <= '0;
      faults_total     <= '0;
      writebacks_total <= '0;
    end else begin
      if (cmd.do_alloc) begin
        page_valid[page_idx] <= 1'b1;
        frames_used          <= frames_used + 1'b1;
      end
      if (cmd.do_evict) begin
        page_valid[q_rdata]  <= 1'b0;
        page_valid[page_idx] <= 1'b1;
      end
      if (cmd.do_rotate || cmd.do_evict) begin
        queue_head <= head_inc;
      end
      if (cmd.guard_clr) begin
        guard <= '0;
      end else if (cmd.do_rotate) begin
        guard <= guard + 1'b1;
      end
      if (cmd.do_alloc || cmd.do_evict) begin
        faults_total <= faults_total + 1'b1;
      end
      if (cmd.do_evict && pr_dirty) begin
        writebacks_total <= writebacks_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status   <= dpr_pkg::ST_OK;
      res_frame    <= '0;
      res_replaced <= 1'b0;
      res_victim   <= '0;
      res_wb       <= 1'b0;
      case (cmd.res_kind)
        dpr_pkg::RES_RANGE:    res_status <= dpr_pkg::ST_RANGE;
        dpr_pkg::RES_MISS:     res_status <= dpr_pkg::ST_MISS;
        dpr_pkg::RES_ACCESS:   res_frame  <= pr_frame;
        dpr_pkg::RES_RESIDENT: begin
          res_status <= dpr_pkg::ST_RESIDENT;
          res_frame  <= pr_frame;
        end
        dpr_pkg::RES_ALLOC:    res_frame  <= FW'(frames_used);
        dpr_pkg::RES_EVICT: begin
          res_frame    <= pr_frame;
          res_replaced <= 1'b1;
          res_victim   <= q_rdata;
          res_wb       <= pr_dirty;
        end
        default: res_status <= dpr_pkg::ST_MISS;
      endcase
    end
  end

  // output word; counters already reflect this item by the time it is pushed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_status          <= res_status;
      out_frame           <= dpr_pkg::FRAME_W'(res_frame);
      out_replaced        <= res_replaced;
      out_victim_page     <= dpr_pkg::PAGE_W'(res_victim);
      out_writeback       <= res_wb;
      out_fault_count     <= faults_total;
      out_writeback_count <= writebacks_total;
    end
  end

  `DPR_ASSERT_IMPL(a_evict_victim_resident, clk, rst, cmd.do_evict,
                   page_valid[q_rdata] && !page_valid[page_idx],
                   "evicted page not resident or faulting page already resident")
  `DPR_ASSERT_IMPL(a_alloc_below_limit, clk, rst, cmd.do_alloc,
                   (LW'(frames_used) < limit) && (frames_used < FUW'(NUM_FRAMES)),
                   "frame allocated beyond limit")
  `DPR_ASSERT_NEXT(a_evict_keeps_count, clk, rst, cmd.do_evict,
                   $stable(frames_used) && (frames_used != '0),
                   "eviction changed frames in use")

endmodule

`default_nettype wire

FILE: rtl/demand_paging_replacement.sv
// Demand paging engine: page table, frame allocator and FIFO / second
// chance replacement for one address space.
// req channel: opcode 0 translates a page (sets chance, dirty on write);
//   opcode 1 loads a faulting page into the lowest free frame or evicts.
// rsp channel: one word per request with status, frame, eviction info and
//   running fault and write-back counts.
// cfg channel: always ready; index 0 max_frames, 1 policy, 2 pages_in_use.
//   Write only while no request is in flight.
// Steps: translates, resident hits and free-frame loads go from the lookup
//   straight to the output push; an eviction first scans the arrival queue,
//   one page per read, wait and check step, rotating each page given a second
//   chance (up to frames in use). Each scan step reads the arrival queue head,
//   then that page's page table entry. One request is in flight at a time; the
//   next is taken once the last has moved into the output register.
// A finished response sits in an output register; the next request is
// accepted while it waits, and its result is held until the receiver takes
// the previous word, so a stalled receiver stalls the engine after one item.
// Reset (synchronous) clears residency, counters and queue pointers and
// restores the config defaults; no clearing pass is needed.
`default_nettype none

module demand_paging_replacement #(
  parameter int NUM_PAGES  = dpr_pkg::NUM_PAGES_DEF,
  parameter int NUM_FRAMES = dpr_pkg::NUM_FRAMES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dpr_req_if.sink   req,
  dpr_rsp_if.source rsp,
  dpr_cfg_if.sink   cfg
);

  dpr_pkg::cmd_t  cmd;
  dpr_pkg::stat_t st;
  logic           in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  dpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dpr_dpath #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg.valid),
    .cfg_index           (cfg.index),
    .cfg_data            (cfg.data),
    .req_opcode          (req.opcode),
    .req_page            (req.page),
    .req_is_write        (req.is_write),
    .cmd                 (cmd),
    .st                  (st),
    .out_ready           (rsp.ready),
    .out_valid           (rsp.valid),
    .out_status          (rsp.status),
    .out_frame           (rsp.frame),
    .out_replaced        (rsp.replaced),
    .out_victim_page     (rsp.victim_page),
    .out_writeback       (rsp.writeback),
    .out_fault_count     (rsp.fault_count),
    .out_writeback_count (rsp.writeback_count)
  );

endmodule

`default_nettype wire

FILE: tb/tb_demand_paging_replacement.sv
// Self-checking testbench for demand_paging_replacement: directed and random
// fault/access traffic checked word by word against an in-bench page engine model.
// Depends on dpr_pkg, the channel interfaces in dpr_if.sv and the RTL top.
`default_nettype none

module tb_demand_paging_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import dpr_pkg::*;

  localparam int NPAGES = NUM_PAGES_DEF;
  localparam int NFRAMES = NUM_FRAMES_DEF;
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FAULT = 1'b1;
  localparam int STALL_LIMIT = 4000;  // cycles with no word moving on any channel
  localparam int DRAIN_PAD = 8;
  localparam int SEG_ITEMS = 62;

  typedef struct packed {
    status_t status;
    logic [FRAME_W-1:0] frame;
    logic replaced;
    logic [PAGE_W-1:0] victim;
    logic wb;
    logic [COUNT_W-1:0] faults;
    logic [COUNT_W-1:0] wbs;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst;

  dpr_req_if req_ch ();
  dpr_rsp_if rsp_ch ();
  dpr_cfg_if cfg_ch ();

  demand_paging_replacement uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // engine model state
  logic [FRAME_W-1:0] pt_frame[NPAGES];
  bit pt_valid[NPAGES];
  bit pt_dirty[NPAGES];
  bit pt_chance[NPAGES];
  logic [PAGE_W-1:0] arrival_pg[NFRAMES];
  int arrival_head;
  int arrival_cnt;
  bit frame_busy[NFRAMES];
  int frames_held;
  logic [COUNT_W-1:0] n_faults;
  logic [COUNT_W-1:0] n_wbs;
  logic [MAXF_W-1:0] lim_cfg;
  bit pol_cfg;
  logic [PIU_W-1:0] npages_cfg;

  rsp_word_t rsp_words_due[$];
  int mismatches;
  int src_idle_pct;
  int rcv_idle_pct;
  int stall_cycles;
  int seg_no;

  function automatic void engine_reset();
    for (int i = 0; i < NPAGES; i++) begin
      pt_frame[i] = '0;
      pt_valid[i] = 1'b0;
      pt_dirty[i] = 1'b0;
      pt_chance[i] = 1'b0;
    end
    for (int i = 0; i < NFRAMES; i++) begin
      arrival_pg[i] = '0;
      frame_busy[i] = 1'b0;
    end
    arrival_head = 0;
    arrival_cnt = 0;
    frames_held = 0;
    n_faults = '0;
    n_wbs = '0;
    lim_cfg = RESET_MAX_FRAMES;
    pol_cfg = 1'b0;
    npages_cfg = RESET_PAGES_IN_USE;
  endfunction

  function automatic void arrival_push(logic [PAGE_W-1:0] pg);
    arrival_pg[(arrival_head + arrival_cnt) % NFRAMES] = pg;
    arrival_cnt++;
  endfunction

  function automatic logic [PAGE_W-1:0] arrival_pop();
    logic [PAGE_W-1:0] pg;
    pg = arrival_pg[arrival_head];
    arrival_head = (arrival_head + 1) % NFRAMES;
    arrival_cnt--;
    return pg;
  endfunction

  function automatic rsp_word_t serve_page_req(logic op, logic [PAGE_W-1:0] pg, logic wr);
    rsp_word_t w;
    int lim;
    int f;
    int g;
    logic [PAGE_W-1:0] v;
    w = '0;
    w.status = ST_OK;
    if ({1'b0, pg} >= npages_cfg) begin
      w.status = ST_RANGE;
    end else if (op == OP_ACCESS) begin
      if (pt_valid[pg]) begin
        w.frame = pt_frame[pg];
        pt_chance[pg] = 1'b1;
        if (wr) pt_dirty[pg] = 1'b1;
      end else begin
        w.status = ST_MISS;
      end
    end else if (pt_valid[pg]) begin
      w.status = ST_RESIDENT;
      w.frame = pt_frame[pg];
    end else begin
      lim = lim_cfg;
      if (lim < 1) lim = 1;
      if (lim > NFRAMES) lim = NFRAMES;
      f = NFRAMES;
      if (frames_held < lim) begin
        f = 0;
        while (f < NFRAMES && frame_busy[f]) f++;
      end
      if (f < NFRAMES) begin
        frame_busy[f] = 1'b1;
        frames_held++;
        w.frame = f[FRAME_W-1:0];
        pt_frame[pg] = f[FRAME_W-1:0];
        pt_valid[pg] = 1'b1;
        pt_dirty[pg] = 1'b0;
        pt_chance[pg] = 1'b0;
        arrival_push(pg);
        n_faults++;
      end else if (arrival_cnt == 0) begin
        w.status = ST_MISS;
      end else begin
        if (pol_cfg) begin
          // head pages with chance set get cleared and rotated to the tail
          g = 0;
          while (g < arrival_cnt && pt_chance[arrival_pg[arrival_head]]) begin
            pt_chance[arrival_pg[arrival_head]] = 1'b0;
            arrival_push(arrival_pop());
            g++;
          end
        end
        v = arrival_pop();
        w.frame = pt_frame[v];
        w.replaced = 1'b1;
        w.victim = v;
        if (pt_dirty[v]) begin
          w.wb = 1'b1;
          n_wbs++;
        end
        pt_valid[v] = 1'b0;
        pt_dirty[v] = 1'b0;
        pt_chance[v] = 1'b0;
        pt_frame[pg] = w.frame;
        pt_valid[pg] = 1'b1;
        pt_dirty[pg] = 1'b0;
        pt_chance[pg] = 1'b1;
        arrival_push(pg);
        n_faults++;
      end
    end
    w.faults = n_faults;
    w.wbs = n_wbs;
    return w;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $error("%s expected %0h got %0h", name, e, a);
      mismatches++;
    end
  endfunction

  // response check first, then config and request words of the same edge
  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_words_due.size() == 0) begin
          $error("response word with none pending");
          mismatches++;
        end else begin
          exp_w = rsp_words_due.pop_front();
          cmp_field("status", exp_w.status, rsp_ch.status);
          cmp_field("frame", exp_w.frame, rsp_ch.frame);
          cmp_field("replaced", exp_w.replaced, rsp_ch.replaced);
          cmp_field("victim_page", exp_w.victim, rsp_ch.victim_page);
          cmp_field("writeback", exp_w.wb, rsp_ch.writeback);
          cmp_field("fault_count", exp_w.faults, rsp_ch.fault_count);
          cmp_field("writeback_count", exp_w.wbs, rsp_ch.writeback_count);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAX_FRAMES: lim_cfg = cfg_ch.data[MAXF_W-1:0];
          CFG_POLICY: pol_cfg = cfg_ch.data[0];
          CFG_PAGES_IN_USE: npages_cfg = cfg_ch.data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready)
        rsp_words_due.push_back(serve_page_req(req_ch.opcode, req_ch.page, req_ch.is_write));
    end
  end

  always @(posedge clk) rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL demand_paging_replacement");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // valid stays high after a word so back-to-back words follow without a drop in valid
  task automatic send_req(logic op, logic [PAGE_W-1:0] pg, logic wr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.page <= pg;
    req_ch.is_write <= wr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] mf, logic pol, logic [CFG_DATA_W-1:0] np);
    cfg_write(CFG_MAX_FRAMES, mf);
    cfg_write(CFG_POLICY, {6'd0, pol});
    cfg_write(CFG_PAGES_IN_USE, np);
    cfg_ch.valid <= 1'b0;
  endtask

  // let the clock tick before checking so the word accepted at the last edge is already queued
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rsp_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic test_directed_fifo();
    send_req(OP_ACCESS, 6'd0, 1'b0);   // not resident
    send_req(OP_FAULT, 6'd63, 1'b0);   // lowest free frame
    send_req(OP_FAULT, 6'd63, 1'b1);   // already resident
    send_req(OP_ACCESS, 6'd63, 1'b1);  // marks dirty
    for (int p = 0; p < 5; p++) send_req(OP_FAULT, p[PAGE_W-1:0], 1'b0);
    send_req(OP_FAULT, 6'd10, 1'b0);   // evicts dirty 63
    send_req(OP_ACCESS, 6'd63, 1'b0);
    send_req(OP_FAULT, 6'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_second_chance_and_limits();
    set_config(7'd6, 1'b1, 7'd8);
    send_req(OP_FAULT, 6'd10, 1'b0);   // out of range, stays resident
    send_req(OP_ACCESS, 6'd0, 1'b1);
    for (int p = 1; p < 5; p++) send_req(OP_ACCESS, p[PAGE_W-1:0], p[0]);
    send_req(OP_FAULT, 6'd5, 1'b0);    // every mark set: full pass then head goes
    wait_drained();
    set_config(7'd0, 1'b1, 7'd0);      // frame limit clamps up, nothing in range
    send_req(OP_FAULT, 6'd1, 1'b0);
    send_req(OP_ACCESS, 6'd1, 1'b0);
    wait_drained();
    set_config(7'd63, 1'b0, 7'd64);    // frame limit clamps down to all frames
    send_req(OP_FAULT, 6'd20, 1'b1);
    send_req(OP_FAULT, 6'd7, 1'b0);
    send_req(OP_ACCESS, 6'd20, 1'b1);
    wait_drained();
  endtask

  task automatic random_segment();
    logic [CFG_DATA_W-1:0] mf;
    logic pol;
    logic [CFG_DATA_W-1:0] np;
    int span;
    logic op;
    logic [PAGE_W-1:0] pg;
    case (seg_no)
      0: begin mf = 7'd1; pol = 1'b1; np = 7'd64; end
      1: begin mf = 7'd32; pol = 1'b0; np = 7'd64; end
      2: begin mf = 7'd63; pol = 1'b1; np = 7'd127; end
      3: begin mf = 7'd0; pol = 1'b0; np = 7'($urandom_range(2, 16)); end
      default: begin
        mf = 7'($urandom_range(2, 10));
        pol = 1'($urandom_range(0, 1));
        np = 7'($urandom_range(mf + 2, 40));
      end
    endcase
    seg_no++;
    set_config(mf, pol, np);
    span = (np > NPAGES) ? NPAGES : np;
    for (int i = 0; i < SEG_ITEMS; i++) begin
      op = ($urandom_range(99) < 45) ? OP_FAULT : OP_ACCESS;
      if ($urandom_range(99) < 80) pg = 6'($urandom_range(0, span - 1));
      else pg = 6'($urandom_range(0, NPAGES - 1));
      send_req(op, pg, 1'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(int src_pct, int rcv_pct);
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    random_segment();
    random_segment();
  endtask

  initial begin
    engine_reset();
    mismatches = 0;
    seg_no = 0;
    src_idle_pct = 23;
    rcv_idle_pct = 81;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_ACCESS;
    req_ch.page = '0;
    req_ch.is_write = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_FRAMES;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_fifo();
    test_second_chance_and_limits();
    test_random_traffic(23, 81);
    test_random_traffic(81, 23);
    test_random_traffic(0, 0);
    wait_drained();

    if (mismatches == 0 && rsp_words_due.size() == 0) begin
      $display("PASS demand_paging_replacement");
    end else begin
      $display("FAIL demand_paging_replacement");
    end
    $finish;
  end

endmodule

`default_nettype wire
